### hw/rtl/kde_pkg.sv
// ----------------------------------------------------------------------------
// kde_pkg
// Shared types and constants for the keypad debounce and edge detect block.
// ----------------------------------------------------------------------------
package kde_pkg;

    localparam int KEY_COUNT   = 8;
    localparam int FIELD_W     = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_SAMPLES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LED_ACTIVE_HIGH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEYS_ACTIVE_LOW  = 2'd2;

    localparam logic [FIELD_W-1:0] DEBOUNCE_RESET = 8'd3;
    localparam logic [FIELD_W-1:0] DEBOUNCE_MIN   = 8'd2;
    localparam logic [FIELD_W-1:0] COUNT_ONE      = 8'd1;

    localparam logic KIND_POLL = 1'b0;
    localparam logic KIND_SEED = 1'b1;

    typedef logic [KEY_COUNT-1:0] key_vec_t;

    typedef struct packed {
        logic               kind;
        logic [FIELD_W-1:0] key_sample;
    } in_item_t;

    typedef struct packed {
        logic [FIELD_W-1:0] pressed_mask;
        logic [FIELD_W-1:0] edge_mask;
        logic [FIELD_W-1:0] led_port;
        logic               led_write;
    } out_item_t;

    typedef struct packed {
        logic [FIELD_W-1:0] threshold;
        logic               led_active_high;
        logic               keys_active_low;
    } cfg_t;

    typedef struct packed {
        logic commit;
        logic level;
    } lane_out_t;

endpackage

### hw/rtl/kde_cfg_regs.sv
// ----------------------------------------------------------------------------
// kde_cfg_regs
// Configuration registers with write port; derives the effective threshold.
// ----------------------------------------------------------------------------
module kde_cfg_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [kde_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [kde_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output kde_pkg::cfg_t                    cfg
);
    import kde_pkg::*;

    logic [FIELD_W-1:0] debounce_reg;
    logic               led_high_reg;
    logic               keys_low_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg <= DEBOUNCE_RESET;
            led_high_reg <= 1'b1;
            keys_low_reg <= 1'b1;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_DEBOUNCE_SAMPLES: debounce_reg <= cfg_wdata[FIELD_W-1:0];
                REG_LED_ACTIVE_HIGH:  led_high_reg <= cfg_wdata[0];
                REG_KEYS_ACTIVE_LOW:  keys_low_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        cfg.threshold       = (debounce_reg < DEBOUNCE_MIN) ? DEBOUNCE_MIN : debounce_reg;
        cfg.led_active_high = led_high_reg;
        cfg.keys_active_low = keys_low_reg;
    end

endmodule

### hw/rtl/kde_key_lane.sv
// ----------------------------------------------------------------------------
// kde_key_lane
// One key: candidate level and consecutive-sample counter, flags a commit.
// ----------------------------------------------------------------------------
module kde_key_lane (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic                         seed,
    input  logic                         level,
    input  logic [kde_pkg::FIELD_W-1:0]  threshold,
    output kde_pkg::lane_out_t           lane
);
    import kde_pkg::*;

    logic               cand_reg;
    logic               cand_next;
    logic [FIELD_W-1:0] cnt_reg;
    logic [FIELD_W-1:0] cnt_next;
    logic [FIELD_W-1:0] cnt_inc;

    assign cnt_inc = cnt_reg + COUNT_ONE;

    always_comb begin
        cand_next   = cand_reg;
        cnt_next    = cnt_reg;
        lane.commit = 1'b0;
        lane.level  = level;
        if (seed) begin
            cand_next = level;
            cnt_next  = threshold;
        end else if (level != cand_reg) begin
            cand_next = level;
            cnt_next  = COUNT_ONE;
        end else if (cnt_reg < threshold) begin
            cnt_next    = cnt_inc;
            lane.commit = (cnt_inc >= threshold);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cand_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (en) begin
            cand_reg <= cand_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

### hw/rtl/keypad_debounce_edge.sv
// ----------------------------------------------------------------------------
// keypad_debounce_edge
// Counter debounce for eight keys with press-edge detect and LED mask output.
// ----------------------------------------------------------------------------
//  channel   ports                         payload
//  input     s_valid / s_ready / s_data    in_item_t  (kind, key_sample)
//  result    m_valid / m_ready / m_data    out_item_t (masks, led_port, write)
//  config    cfg_we / cfg_index / cfg_wdata  debounce, LED and key polarity
//
//  One item per cycle sustained while the result side is not stalled.
//  Items go through an input register, then all key lanes update in parallel
//  into the result register. A stalled result holds the input register, and
//  s_ready drops only when both registers are full and m_ready is low. Reset
//  (aresetn low, synchronous) clears counters, candidates and masks; LEDs
//  start all lit.
// ----------------------------------------------------------------------------
module keypad_debounce_edge (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  kde_pkg::in_item_t                s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output kde_pkg::out_item_t               m_data,
    input  logic                             cfg_we,
    input  logic [kde_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [kde_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import kde_pkg::*;

    cfg_t               cfg;
    logic               in_vld_reg;
    in_item_t           in_reg;
    logic               out_vld_reg;
    out_item_t          out_reg;
    out_item_t          out_next;
    key_vec_t           deb_reg;
    key_vec_t           deb_next;
    key_vec_t           edge_vec;
    logic [FIELD_W-1:0] lit_reg;
    logic [FIELD_W-1:0] lit_next;
    logic [FIELD_W-1:0] sample_pol;
    key_vec_t           sample_keys;
    logic               seed;
    logic               advance;
    lane_out_t          lanes [KEY_COUNT];

    kde_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    assign advance     = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready     = !in_vld_reg || advance;
    assign seed        = (in_reg.kind == KIND_SEED);
    assign sample_pol  = cfg.keys_active_low ? ~in_reg.key_sample : in_reg.key_sample;
    assign sample_keys = sample_pol[KEY_COUNT-1:0];

    for (genvar i = 0; i < KEY_COUNT; i++) begin : g_lane
        kde_key_lane u_lane (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (advance),
            .seed      (seed),
            .level     (sample_keys[i]),
            .threshold (cfg.threshold),
            .lane      (lanes[i])
        );
    end

    always_comb begin
        for (int i = 0; i < KEY_COUNT; i++) begin
            if (seed) begin
                deb_next[i] = sample_keys[i];
                edge_vec[i] = 1'b0;
            end else begin
                deb_next[i] = lanes[i].commit ? lanes[i].level : deb_reg[i];
                edge_vec[i] = lanes[i].commit && lanes[i].level && !deb_reg[i];
            end
        end
        lit_next              = seed ? lit_reg : ~FIELD_W'(deb_next);
        out_next.pressed_mask = FIELD_W'(deb_next);
        out_next.edge_mask    = FIELD_W'(edge_vec);
        out_next.led_port     = cfg.led_active_high ? lit_next : ~lit_next;
        out_next.led_write    = (lit_next != lit_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            deb_reg     <= '0;
            lit_reg     <= '1;
        end else begin
            if (s_valid && s_ready) begin
                in_vld_reg <= 1'b1;
            end else if (advance) begin
                in_vld_reg <= 1'b0;
            end
            if (advance) begin
                out_vld_reg <= 1'b1;
                deb_reg     <= deb_next;
                lit_reg     <= lit_next;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (advance) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_vld_reg;
    assign m_data  = out_reg;

    a_edge_in_pressed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_data.edge_mask & ~m_data.pressed_mask) == '0))
        else $error("edge bit set for a key that is not pressed");

    a_seed_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && seed |=> m_valid && (m_data.edge_mask == '0) && !m_data.led_write)
        else $error("seed item produced an edge or LED write");

    a_hold_input: assert property (@(posedge aclk) disable iff (!aresetn)
        in_vld_reg && !advance |=> in_vld_reg && $stable(in_reg))
        else $error("stalled item lost from input register");

    a_led_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && !seed |=> lit_reg == ~FIELD_W'(deb_reg))
        else $error("LED mask out of step with pressed mask");

endmodule

### bench/kde_scoreboard_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// kde_scoreboard_pkg
// Debounce predictor and result checker for the keypad debounce bench. Each
// accepted sample is run through a cycle-free copy of the per-key counters and
// the expected report is queued, then compared field by field on arrival.
// ----------------------------------------------------------------------------
package kde_scoreboard_pkg;

    import kde_pkg::*;

    localparam logic [FIELD_W-1:0] KEY_MASK = FIELD_W'((1 << KEY_COUNT) - 1);

    class keypad_scoreboard;

        logic [CFG_DATA_W-1:0] debounce_setting;
        logic                  led_active_high;
        logic                  keys_active_low;

        logic [KEY_COUNT-1:0]  candidate;
        logic [FIELD_W-1:0]    stable_count [KEY_COUNT];
        logic [FIELD_W-1:0]    pressed;
        logic [FIELD_W-1:0]    lit;

        out_item_t             expected_reports [$];
        int                    errors;

        function new();
            int i;
            debounce_setting = DEBOUNCE_RESET;
            led_active_high  = 1'b1;
            keys_active_low  = 1'b1;
            candidate        = '0;
            for (i = 0; i < KEY_COUNT; i++) stable_count[i] = '0;
            pressed          = '0;
            lit              = '1;
            errors           = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_DEBOUNCE_SAMPLES: debounce_setting = val;
                REG_LED_ACTIVE_HIGH:  led_active_high  = val[0];
                REG_KEYS_ACTIVE_LOW:  keys_active_low  = val[0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction

        function void note_input(in_item_t item);
            int                 i;
            logic [FIELD_W-1:0] level;
            logic [FIELD_W-1:0] thr;
            logic [FIELD_W-1:0] edges;
            logic [FIELD_W-1:0] new_lit;
            logic               prev;
            logic               wr;
            out_item_t          report;

            thr   = (debounce_setting < DEBOUNCE_MIN) ? DEBOUNCE_MIN : debounce_setting;
            level = keys_active_low ? ~item.key_sample : item.key_sample;
            level = level & KEY_MASK;
            edges = '0;
            wr    = 1'b0;

            if (item.kind == KIND_SEED) begin
                pressed = level;
                for (i = 0; i < KEY_COUNT; i++) begin
                    candidate[i]    = level[i];
                    stable_count[i] = thr;
                end
            end else begin
                for (i = 0; i < KEY_COUNT; i++) begin
                    prev = pressed[i];
                    if (level[i] != candidate[i]) begin
                        candidate[i]    = level[i];
                        stable_count[i] = COUNT_ONE;
                    end else if (stable_count[i] < thr) begin
                        stable_count[i] = stable_count[i] + COUNT_ONE;
                        if (stable_count[i] >= thr) begin
                            pressed[i] = level[i];
                            if (level[i] && !prev) edges[i] = 1'b1;
                        end
                    end
                end
                new_lit = ~pressed;
                if (new_lit != lit) begin
                    lit = new_lit;
                    wr  = 1'b1;
                end
            end

            report.pressed_mask = pressed;
            report.edge_mask    = edges;
            report.led_port     = led_active_high ? lit : ~lit;
            report.led_write    = wr;
            expected_reports.push_back(report);
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (expected_reports.size() == 0) begin
                $error("unexpected item: pressed_mask %0h edge_mask %0h led_port %0h led_write %0b",
                       got.pressed_mask, got.edge_mask, got.led_port, got.led_write);
                errors++;
                return;
            end
            want = expected_reports.pop_front();
            if (got.pressed_mask !== want.pressed_mask) begin
                $error("pressed_mask expected %0h, got %0h", want.pressed_mask, got.pressed_mask);
                errors++;
            end
            if (got.edge_mask !== want.edge_mask) begin
                $error("edge_mask expected %0h, got %0h", want.edge_mask, got.edge_mask);
                errors++;
            end
            if (got.led_port !== want.led_port) begin
                $error("led_port expected %0h, got %0h", want.led_port, got.led_port);
                errors++;
            end
            if (got.led_write !== want.led_write) begin
                $error("led_write expected %0b, got %0b", want.led_write, got.led_write);
                errors++;
            end
        endfunction

    endclass

endpackage

### bench/tb_keypad_debounce_edge.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_keypad_debounce_edge
// Drives key samples and seeds through the debounce block under random
// handshake gaps, long output stalls and several debounce and polarity
// settings, and checks every report against the scoreboard's prediction.
// ----------------------------------------------------------------------------
module tb_keypad_debounce_edge;

    import kde_pkg::*;
    import kde_scoreboard_pkg::*;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    in_item_t              s_data;
    logic                  m_valid;
    logic                  m_ready;
    out_item_t             m_data;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    keypad_scoreboard      sb;
    logic                  steady = 1'b0;
    int                    results_seen = 0;

    keypad_debounce_edge DUT (.*);

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    task automatic send_item(input logic kind, input logic [FIELD_W-1:0] sample);
        int       gap;
        in_item_t item;
        item.kind       = kind;
        item.key_sample = sample;
        gap = 0;
        if (!steady) begin
            while ($urandom_range(99) < 16) gap++;
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(item);
    endtask

    task automatic send_run(input logic kind, input logic [FIELD_W-1:0] sample, input int n);
        int k;
        for (k = 0; k < n; k++) send_item(kind, sample);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] thr, input logic lah, input logic kal);
        cfg_we    <= 1'b1;
        cfg_index <= REG_DEBOUNCE_SAMPLES;
        cfg_wdata <= thr;
        @(posedge aclk);
        sb.set_register(REG_DEBOUNCE_SAMPLES, thr);
        cfg_index <= REG_LED_ACTIVE_HIGH;
        cfg_wdata <= CFG_DATA_W'(lah);
        @(posedge aclk);
        sb.set_register(REG_LED_ACTIVE_HIGH, CFG_DATA_W'(lah));
        cfg_index <= REG_KEYS_ACTIVE_LOW;
        cfg_wdata <= CFG_DATA_W'(kal);
        @(posedge aclk);
        sb.set_register(REG_KEYS_ACTIVE_LOW, CFG_DATA_W'(kal));
        cfg_we    <= 1'b0;
    endtask

    task automatic random_phase(input logic [CFG_DATA_W-1:0] thr, input logic lah,
                                input logic kal, input int count);
        int                 sent;
        int                 len;
        int                 pick;
        int                 eff;
        int                 j;
        logic [FIELD_W-1:0] base;
        logic [FIELD_W-1:0] sample;
        set_config(thr, lah, kal);
        eff  = (thr < DEBOUNCE_MIN) ? DEBOUNCE_MIN : thr;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(99);
            if (pick < 10) begin
                send_item(KIND_SEED, FIELD_W'($urandom));
                sent++;
            end else if (pick < 20) begin
                send_item(KIND_POLL, FIELD_W'($urandom));
                sent++;
            end else begin
                base = FIELD_W'($urandom);
                len  = ($urandom_range(99) < 70) ? eff + $urandom_range(2)
                                                  : $urandom_range(eff, 1);
                if (len > count - sent) len = count - sent;
                for (j = 0; j < len; j++) begin
                    sample = base;
                    if (j < len - eff && $urandom_range(99) < 20)
                        sample = sample ^ FIELD_W'(1 << $urandom_range(7));
                    send_item(KIND_POLL, sample);
                end
                sent += len;
            end
        end
        wait_drained();
    endtask

    initial begin
        sb = new();
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_DEBOUNCE_SAMPLES;
        cfg_wdata <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_run(KIND_POLL, 8'hFF, 1);
        send_run(KIND_POLL, 8'h00, 3);
        send_run(KIND_POLL, 8'hFF, 3);
        send_run(KIND_SEED, 8'h5A, 1);
        send_run(KIND_POLL, 8'h5A, 1);
        wait_drained();

        set_config(8'd0, 1'b0, 1'b0);
        send_run(KIND_POLL, 8'hC3, 2);
        wait_drained();
        set_config(8'd1, 1'b1, 1'b0);
        send_run(KIND_POLL, 8'h3C, 2);
        wait_drained();

        set_config(8'd8, 1'b1, 1'b0);
        send_run(KIND_POLL, 8'hF0, 4);
        wait_drained();
        set_config(8'd3, 1'b1, 1'b0);
        send_run(KIND_POLL, 8'hF0, 1);
        send_run(KIND_POLL, 8'h0F, 3);
        wait_drained();

        random_phase(8'd3, 1'b1, 1'b1, 60);
        steady = 1'b1;
        random_phase(8'd2, 1'b0, 1'b0, 60);
        steady = 1'b0;
        random_phase(8'd0, 1'b1, 1'b0, 40);
        random_phase(8'd1, 1'b0, 1'b1, 40);
        random_phase(8'd255, 1'b1, 1'b1, 260);
        random_phase(CFG_DATA_W'($urandom_range(12, 4)), 1'($urandom), 1'($urandom), 40);

        if (sb.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                sb.check_result(m_data);
                results_seen++;
                if (results_seen == 30 || results_seen == 350) hold_left = 80;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= steady || ($urandom_range(99) >= 16);
            end
        end
    end

    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/kde_pkg.sv
hw/rtl/kde_cfg_regs.sv
hw/rtl/kde_key_lane.sv
hw/rtl/keypad_debounce_edge.sv
bench/kde_scoreboard_pkg.sv
bench/tb_keypad_debounce_edge.sv
